FILE: src/b64d_pkg.sv
// ---------------------------------------------------------------------------
// b64d_pkg
// shared types and the character classifier of the base64 decoder
// ---------------------------------------------------------------------------
package b64d_pkg;

    localparam int ACC_W  = 18;
    localparam int WORD_W = 24;

    // number of bytes a group yields
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;
    localparam logic [1:0] CNT_THREE = 2'd3;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PAD   = 8'h3D;

    // one queued request for the back end: a finished group or an error
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [1:0]        cnt;
        logic              msg_last;
        logic              err;
    } b64d_grp_t;

    typedef struct packed {
        logic       is_alpha;
        logic       is_pad;
        logic [5:0] val;
    } b64d_class_t;

    function automatic b64d_class_t classify(input logic [7:0] c);
        b64d_class_t r;
        logic [7:0]  t;
        r = '0;
        t = '0;
        if (c == CH_PLUS) begin
            r.is_alpha = 1'b1;
            r.val      = 6'd62;
        end else if (c == CH_SLASH) begin
            r.is_alpha = 1'b1;
            r.val      = 6'd63;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            t          = c - 8'd65;
            r.is_alpha = 1'b1;
            r.val      = t[5:0];
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            t          = c - 8'd71;
            r.is_alpha = 1'b1;
            r.val      = t[5:0];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t          = c + 8'd4;
            r.is_alpha = 1'b1;
            r.val      = t[5:0];
        end else if (c == CH_PAD) begin
            r.is_pad = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: src/b64d_front.sv
// ---------------------------------------------------------------------------
// b64d_front
// takes characters, tracks the group and queues finished groups or errors
// ---------------------------------------------------------------------------
module b64d_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_fire,
    input  logic [7:0]            in_char,
    input  logic                  in_last,
    output logic                  push,
    output b64d_pkg::b64d_grp_t   push_grp
);

    logic [1:0]                   pos_reg, pos_next;
    logic [b64d_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic                         pad_reg, pad_next;
    b64d_pkg::b64d_class_t        cls;
    logic [b64d_pkg::ACC_W+5:0]   shifted;

    assign cls     = b64d_pkg::classify(in_char);
    assign shifted = {acc_reg, 6'd0};

    always_comb begin
        pos_next = pos_reg;
        acc_next = acc_reg;
        pad_next = pad_reg;
        push     = 1'b0;
        push_grp = '0;
        push_grp.cnt = b64d_pkg::CNT_ONE;
        if (in_fire) begin
            if (!cls.is_alpha && !cls.is_pad) begin
                push         = 1'b1;
                push_grp.err = 1'b1;
            end else if (cls.is_pad) begin
                if (pos_reg == 2'd2 && !in_last) begin
                    // first of two pads, group waits for the closing one
                    acc_next = shifted[b64d_pkg::ACC_W-1:0];
                    pad_next = 1'b1;
                    pos_next = 2'd3;
                end else if (pos_reg == 2'd3 && in_last) begin
                    push              = 1'b1;
                    push_grp.word     = shifted;
                    push_grp.cnt      = pad_reg ? b64d_pkg::CNT_ONE : b64d_pkg::CNT_TWO;
                    push_grp.msg_last = 1'b1;
                end else begin
                    push         = 1'b1;
                    push_grp.err = 1'b1;
                end
            end else begin
                if (pad_reg) begin
                    push         = 1'b1;
                    push_grp.err = 1'b1;
                end else if (pos_reg != 2'd3) begin
                    if (in_last) begin
                        push         = 1'b1;
                        push_grp.err = 1'b1;
                    end else begin
                        acc_next = shifted[b64d_pkg::ACC_W-1:0] | b64d_pkg::ACC_W'(cls.val);
                        pos_next = pos_reg + 2'd1;
                    end
                end else begin
                    push              = 1'b1;
                    push_grp.word     = {acc_reg, cls.val};
                    push_grp.cnt      = b64d_pkg::CNT_THREE;
                    push_grp.msg_last = in_last;
                end
            end
            // any pushed request closes the group
            if (push) begin
                pos_next = '0;
                acc_next = '0;
                pad_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            acc_reg <= '0;
            pad_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            pad_reg <= pad_next;
        end
    end

endmodule

FILE: src/b64d_queue.sv
// ---------------------------------------------------------------------------
// b64d_queue
// small fifo of group requests between front and back end
// ---------------------------------------------------------------------------
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  b64d_pkg::b64d_grp_t   push_grp,
    output logic                  full,
    output logic                  nonempty,
    output b64d_pkg::b64d_grp_t   head,
    input  logic                  pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    b64d_pkg::b64d_grp_t entry_reg [DEPTH];
    logic [AW:0] wptr_reg, rptr_reg;

    // wrap bits differ and slot bits match: every slot holds a request
    assign full     = (wptr_reg[AW] != rptr_reg[AW])
                      && (wptr_reg[AW-1:0] == rptr_reg[AW-1:0]);
    assign nonempty = (wptr_reg != rptr_reg);
    assign head     = entry_reg[rptr_reg[AW-1:0]];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg[AW-1:0]] <= push_grp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg[AW-1:0] == AW'(DEPTH-1))
                            ? {~wptr_reg[AW], {AW{1'b0}}} : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg[AW-1:0] == AW'(DEPTH-1))
                            ? {~rptr_reg[AW], {AW{1'b0}}} : rptr_reg + 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !nonempty))
        else $error("queue pop while empty");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, wptr_reg[AW-1:0]} < (AW+1)'(DEPTH)
        && {1'b0, rptr_reg[AW-1:0]} < (AW+1)'(DEPTH))
        else $error("queue pointer out of range");

endmodule

FILE: src/b64d_back.sv
// ---------------------------------------------------------------------------
// b64d_back
// splits a queued group into output register bytes, one per unstalled cycle
// ---------------------------------------------------------------------------
module b64d_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  b64d_pkg::b64d_grp_t   head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_run_last,
    output logic                  out_msg_last,
    output logic                  out_err
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       run_reg, msg_reg, err_reg;
    logic       load;
    logic       final_byte;
    logic [7:0] sel_byte;

    assign load       = !valid_reg || out_ready;
    assign final_byte = (idx_reg == (head.cnt - 2'd1));
    assign pop        = load && head_valid && final_byte;

    always_comb begin
        case (idx_reg)
            2'd0:    sel_byte = head.word[23:16];
            2'd1:    sel_byte = head.word[15:8];
            default: sel_byte = head.word[7:0];
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        if (load && head_valid) begin
            idx_next = final_byte ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                valid_reg <= head_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && head_valid) begin
            byte_reg <= sel_byte;
            run_reg  <= final_byte;
            msg_reg  <= final_byte && head.msg_last && !head.err;
            err_reg  <= head.err;
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign out_run_last = run_reg;
    assign out_msg_last = msg_reg;
    assign out_err      = err_reg;

endmodule

FILE: src/base64_stream_decoder.sv
// ---------------------------------------------------------------------------
// base64_stream_decoder
// base64 text to bytes, one character in and one byte out per unstalled cycle
// ---------------------------------------------------------------------------
// first byte of a group: the closing character's request is written to the
//   queue, then the byte is loaded into the output register
// throughput: one character in per cycle while the queue has room, one byte
//   out per cycle while the output is taken; a full group of four characters
//   gives three bytes and an error one; the request queue absorbs error bursts
// reset: aresetn low clears group state, queue pointers and output valid
// ---------------------------------------------------------------------------
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = 4      // group requests held between the parts
) (
    input  logic       aclk,
    input  logic       aresetn,
    // character input
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] enc_char
    input  logic       s_axis_tlast,   // is_last
    // decoded byte output
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tlast,   // last_of_run
    output logic [1:0] m_axis_tuser    // [0] end_of_message, [1] error
);

    logic                  in_fire;
    logic                  push;
    b64d_pkg::b64d_grp_t   push_grp;
    logic                  q_full;
    logic                  q_nonempty;
    b64d_pkg::b64d_grp_t   q_head;
    logic                  q_pop;
    logic                  msg_last;
    logic                  err;

    // a character is taken whenever the queue has room for what it may cause
    assign s_axis_tready = !q_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // front: classify, gather sextets, raise group or error requests
    b64d_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_char  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .push     (push),
        .push_grp (push_grp)
    );

    // decouples character intake from byte output
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_grp (push_grp),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (q_head),
        .pop      (q_pop)
    );

    // back: one byte per cycle into the output register unless it stalls
    b64d_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_valid   (q_nonempty),
        .head         (q_head),
        .pop          (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (m_axis_tdata),
        .out_run_last (m_axis_tlast),
        .out_msg_last (msg_last),
        .out_err      (err)
    );

    assign m_axis_tuser = {err, msg_last};

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && err |-> m_axis_tdata == 8'd0 && !msg_last && m_axis_tlast)
        else $error("error result carries data or end marks wrong");

    a_msg_on_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && msg_last |-> m_axis_tlast)
        else $error("end of message not on last byte of a group");

    // the request is written into the queue, then loaded into the output register
    a_out_after_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("queued request did not reach the output");

endmodule

FILE: verif/b64d_stream_checker.sv
// ---------------------------------------------------------------------------
// b64d_stream_checker
// watches both channels of the base64 decoder and checks each decoded byte
// ---------------------------------------------------------------------------
module b64d_stream_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] enc_char
    input  logic       s_axis_tlast,   // is_last
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] data_byte
    input  logic       m_axis_tlast,   // last_of_run
    input  logic [1:0] m_axis_tuser,   // [0] end_of_message, [1] error
    output int         fail_count,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       msg_end;
        logic       err;
    } dec_byte_t;

    dec_byte_t   byte_q[$];

    // group state of the decoder as seen from outside
    logic [1:0]  grp_pos   = '0;
    logic [17:0] sextets   = '0;
    logic        pad_taken = 1'b0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0h, expected %0h at %0t",
                 what, got, want, $realtime);
        fail_count++;
    endtask

    // turns one character into the decoded bytes it releases
    task automatic decode_char(input logic [7:0] c, input logic last);
        logic        alpha;
        logic        pad;
        logic [5:0]  v;
        logic [23:0] word;
        logic        bad;
        int          n;
        dec_byte_t   b;
        alpha = 1'b1;
        pad   = 1'b0;
        v     = '0;
        bad   = 1'b0;
        n     = 0;
        word  = '0;
        if (c == b64d_pkg::CH_PLUS) begin
            v = 6'd62;
        end else if (c == b64d_pkg::CH_SLASH) begin
            v = 6'd63;
        end else if (c >= 8'h41 && c <= 8'h5A) begin        // upper case
            v = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin        // lower case
            v = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin        // digits
            v = 6'(c - 8'h30 + 8'd52);
        end else if (c == b64d_pkg::CH_PAD) begin
            alpha = 1'b0;
            pad   = 1'b1;
        end else begin
            alpha = 1'b0;
        end

        if (!alpha && !pad) begin
            bad = 1'b1;
        end else if (pad) begin
            if (grp_pos < 2'd2) begin
                bad = 1'b1;
            end else if (grp_pos == 2'd2) begin
                // first of two pads: must be followed by a closing pad
                if (last) begin
                    bad = 1'b1;
                end else begin
                    sextets   = {sextets[11:0], 6'd0};
                    pad_taken = 1'b1;
                    grp_pos   = 2'd3;
                end
            end else if (!last) begin
                bad = 1'b1;
            end else begin
                word = {sextets, 6'd0};
                n    = pad_taken ? 1 : 2;
            end
        end else begin
            if (pad_taken) begin
                bad = 1'b1;
            end else if (grp_pos < 2'd3) begin
                if (last) begin
                    bad = 1'b1;
                end else begin
                    sextets = {sextets[11:0], v};
                    grp_pos = grp_pos + 2'd1;
                end
            end else begin
                word = {sextets, v};
                n    = 3;
            end
        end

        if (bad) begin
            b = '{data: 8'h00, run_end: 1'b1, msg_end: 1'b0, err: 1'b1};
            byte_q.push_back(b);
        end
        for (int k = 0; k < n; k++) begin
            b.data    = word[23 - 8*k -: 8];
            b.run_end = (k == n - 1);
            b.msg_end = (k == n - 1) && last;
            b.err     = 1'b0;
            byte_q.push_back(b);
        end
        if (bad || n > 0) begin
            grp_pos   = '0;
            sextets   = '0;
            pad_taken = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        dec_byte_t want;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                decode_char(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (byte_q.size() == 0) begin
                    flag_mismatch("unexpected byte", m_axis_tdata, 0);
                end else begin
                    want = byte_q.pop_front();
                    if (m_axis_tdata !== want.data)
                        flag_mismatch("data_byte", m_axis_tdata, want.data);
                    if (m_axis_tlast !== want.run_end)
                        flag_mismatch("last_of_run", m_axis_tlast, want.run_end);
                    if (m_axis_tuser[0] !== want.msg_end)
                        flag_mismatch("end_of_message", m_axis_tuser[0], want.msg_end);
                    if (m_axis_tuser[1] !== want.err)
                        flag_mismatch("error", m_axis_tuser[1], want.err);
                end
            end
            pending <= byte_q.size();
        end
    end

endmodule

FILE: verif/tb_base64_stream_decoder.sv
// ---------------------------------------------------------------------------
// tb_base64_stream_decoder
// drives base64 text into the decoder and reports the checker's verdict
// ---------------------------------------------------------------------------
// directed text first (standard groups, both pad forms, bad bytes and misplaced
// pads), then random messages, mostly well formed with random
// content and some damaged; both sides idle at random with calm stretches
// ---------------------------------------------------------------------------
module tb_base64_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    // damage applied to a random message
    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_BYTE,
        FLAW_SHORT,
        FLAW_EXTRA_PAD
    } flaw_t;

    localparam int RANDOM_ITEMS = 140;
    localparam int DRAIN_LIMIT  = 5000;

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;    // [7:0] enc_char
    logic       s_axis_tlast  = 1'b0;  // is_last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [7:0] data_byte
    logic       m_axis_tlast;          // last_of_run
    logic [1:0] m_axis_tuser;          // [0] end_of_message, [1] error

    int fail_count;
    int pending;
    int chars_sent  = 0;
    int send_calm   = 0;   // requests left in a stretch with no idling
    int accept_calm = 0;

    base64_stream_decoder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    b64d_stream_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // idle cycles before a request, with now and then a run of zero gaps
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // alphabet character for a sextet value
    function automatic logic [7:0] b64_char(input int v);
        if (v < 26)
            return 8'(8'h41 + v);          // upper case
        if (v < 52)
            return 8'(8'h61 + v - 26);     // lower case
        if (v < 62)
            return 8'(8'h30 + v - 52);     // digits
        return (v == 62) ? b64d_pkg::CH_PLUS : b64d_pkg::CH_SLASH;
    endfunction

    // one character request; tvalid is only lowered when a gap follows,
    // so back-to-back requests never see two assignments in one step
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        chars_sent++;
    endtask

    task automatic send_text(input string txt, input logic last_at_end);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], last_at_end && (i == txt.len() - 1));
    endtask

    // random message of one to four groups, with optional padding and damage
    task automatic send_message();
        logic [7:0] chars[$];
        int         groups;
        int         pads;
        int         cut;
        logic       ends;
        flaw_t      flaw;
        groups = $urandom_range(1, 4);
        for (int i = 0; i < 4 * groups; i++)
            chars.push_back(b64_char($urandom_range(0, 63)));
        pads = $urandom_range(0, 2);
        for (int j = 0; j < pads; j++)
            chars[chars.size() - 1 - j] = b64d_pkg::CH_PAD;
        case ($urandom_range(0, 9))
            7:       flaw = FLAW_BAD_BYTE;
            8:       flaw = FLAW_SHORT;
            9:       flaw = FLAW_EXTRA_PAD;
            default: flaw = FLAW_NONE;
        endcase
        case (flaw)
            FLAW_BAD_BYTE: begin
                chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
            end
            FLAW_SHORT: begin
                cut = $urandom_range(1, 3);
                repeat (cut) void'(chars.pop_back());
            end
            FLAW_EXTRA_PAD: begin
                chars.insert($urandom_range(0, chars.size() - 1), b64d_pkg::CH_PAD);
            end
            default: ;
        endcase
        // now and then the message runs on into the next one
        ends = ($urandom_range(0, 9) != 0);
        foreach (chars[i])
            send_char(chars[i], ends && (i == chars.size() - 1));
    endtask

    // result side: random stall before each decoded byte
    initial begin
        int gap;
        forever begin
            gap = draw_gap(accept_calm);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    initial begin
        int start_count;
        int waited;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // standard full group, then both padded closings
        send_text("TWFu", 1'b1);
        send_text("+/Z=", 1'b1);
        send_text("TQ==", 1'b1);
        // bytes outside the alphabet at both extremes
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        // pad as first character of a group
        send_char(b64d_pkg::CH_PAD, 1'b0);
        // alphabet character after a pad, lower case and digits on the way
        send_text("a9=z", 1'b0);
        // closing pad that does not end the message
        send_text("AB==", 1'b0);
        // message ending on the first of two pads
        send_text("AB=", 1'b1);
        // message ending inside a group
        send_char(8'h51, 1'b1);

        start_count = chars_sent;
        while (chars_sent - start_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
                // loose noise: any byte, any last flag
                repeat ($urandom_range(1, 3))
                    send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                send_message();
            end
        end
        s_axis_tvalid <= 1'b0;
        // let the checker's count take in the last request
        @(posedge aclk);

        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        // catch any stray byte after the last expected one
        repeat (30) @(posedge aclk);
        if (pending != 0)
            $display("%0d decoded bytes never arrived", pending);

        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
